[hdl/swsc_pkg.sv]
// Shared types and constants for the spread weight sigma cap block.
// No dependencies; used by swsc_ctrl, swsc_dp and spread_weight_sigma_cap.
package swsc_pkg;

   localparam int WEIGHT_W = 23;
   localparam int SUM_W    = 29;
   localparam int SQ_W     = 52;
   localparam int DIFF_W   = 58;
   localparam int ROOT_W   = 29;
   localparam int NUM_W    = 46;
   localparam int DVD_W    = 34;
   localparam int CNT_W    = 6;

   localparam logic [31:0]         SPREAD_FLOOR = 32'd655;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX   = 23'd6553600;
   localparam logic [31:0]         RECIP_REM0   = 32'd512;   // 2^32 >> 23
   localparam logic [CNT_W-1:0]    RECIP_STEPS  = 6'd23;
   localparam logic [CNT_W-1:0]    CAP_STEPS    = 6'd34;
   localparam logic [DIFF_W-1:0]   ROOT_BIT0    = 58'd1 << 56;
   localparam logic [15:0]         SIGMA_RESET  = 16'd12288;
   localparam logic [2:0]          ADDR_SIGMA   = 3'd0;

   typedef struct packed {
      logic [31:0] bid_price;
      logic [31:0] ask_price;
      logic        last_quote;
   } req_payload_type;

   typedef struct packed {
      logic [WEIGHT_W-1:0] weight;
      logic [5:0]          quote_index;
      logic                last_weight;
      logic                overflow;
   } rsp_payload_type;

   typedef struct packed {
      logic capture;
      logic div_step;
      logic store;
      logic sq_rd;
      logic nq;
      logic ss;
      logic diff;
      logic root_step;
      logic cap_num;
      logic cap_div_start;
      logic emit_rd;
      logic emit_next;
      logic set_clear;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic in_last;
      logic last;
      logic div_done;
      logic sq_idx_end;
      logic sq_done;
      logic root_done;
      logic emit_last;
   } status_type;

endpackage

[hdl/swsc_ctrl.sv]
// Sequencer for the spread weight sigma cap block: handshakes and datapath commands.
// Depends on swsc_pkg.
module swsc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  swsc_pkg::status_type status,
   output swsc_pkg::cmd_type    cmd
);

   typedef enum logic [12:0] {
      S_IDLE  = 13'b0000000000001,
      S_DIV   = 13'b0000000000010,
      S_STORE = 13'b0000000000100,
      S_SQ    = 13'b0000000001000,
      S_NQ    = 13'b0000000010000,
      S_SS    = 13'b0000000100000,
      S_DIFF  = 13'b0000001000000,
      S_ROOT  = 13'b0000010000000,
      S_CAP   = 13'b0000100000000,
      S_CLOAD = 13'b0001000000000,
      S_CDIV  = 13'b0010000000000,
      S_ERD   = 13'b0100000000000,
      S_EOUT  = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_EOUT);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (!status.full) state_in = S_DIV;
               else if (status.in_last) state_in = S_SQ;
            end
         end
         S_DIV: begin
            if (status.div_done) state_in = S_STORE;
            else cmd.div_step = 1'b1;
         end
         S_STORE: begin
            cmd.store = 1'b1;
            state_in  = status.last ? S_SQ : S_IDLE;
         end
         S_SQ: begin
            cmd.sq_rd = !status.sq_idx_end;
            if (status.sq_done) state_in = S_NQ;
         end
         S_NQ: begin
            cmd.nq   = 1'b1;
            state_in = S_SS;
         end
         S_SS: begin
            cmd.ss   = 1'b1;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            if (status.root_done) state_in = S_CAP;
            else cmd.root_step = 1'b1;
         end
         S_CAP: begin
            cmd.cap_num = 1'b1;
            state_in    = S_CLOAD;
         end
         S_CLOAD: begin
            cmd.cap_div_start = 1'b1;
            state_in          = S_CDIV;
         end
         S_CDIV: begin
            if (status.div_done) state_in = S_ERD;
            else cmd.div_step = 1'b1;
         end
         S_ERD: begin
            cmd.emit_rd = 1'b1;
            state_in    = S_EOUT;
         end
         S_EOUT: begin
            if (rsp_ready) begin
               cmd.emit_next = 1'b1;
               if (status.emit_last) begin
                  cmd.set_clear = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_ERD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule

[hdl/swsc_dp.sv]
// Datapath: weight store, shared shift-subtract divider, sums, integer root, cap.
// Depends on swsc_pkg; driven by swsc_ctrl commands.
module swsc_dp #(
   parameter int MAX_QUOTES = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  swsc_pkg::cmd_type         cmd,
   input  swsc_pkg::req_payload_type req_payload,
   input  logic [15:0]               sigma,
   output swsc_pkg::rsp_payload_type rsp_payload,
   output swsc_pkg::status_type      status
);

   localparam int AW = $clog2(MAX_QUOTES);
   localparam int CW = $clog2(MAX_QUOTES + 1);
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_QUOTES);

   logic [swsc_pkg::WEIGHT_W-1:0] store_mem [MAX_QUOTES];
   logic [swsc_pkg::WEIGHT_W-1:0] rd_data_ff;
   logic                          rdv_ff;

   logic [CW-1:0]                 count_ff, idx_ff;
   logic [swsc_pkg::SUM_W-1:0]    sum_ff;
   logic                          dropped_ff, last_ff;
   logic [swsc_pkg::SQ_W-1:0]     q_ff;
   logic [swsc_pkg::DIFF_W-1:0]   p1_ff, p2_ff;
   logic [swsc_pkg::DIFF_W-1:0]   x_ff, r_ff, bit_ff;
   logic [swsc_pkg::NUM_W-1:0]    num_ff;

   logic [31:0]                   div_rem_ff, div_dvs_ff;
   logic [swsc_pkg::DVD_W-1:0]    div_dvd_ff, div_quo_ff;
   logic [swsc_pkg::CNT_W-1:0]    div_cnt_ff;

   logic [31:0]                   abs_diff, spread;
   logic [32:0]                   div_sh, div_sub;
   logic                          div_ge;
   logic [swsc_pkg::WEIGHT_W-1:0] w_sat;
   logic [swsc_pkg::DIFF_W-1:0]   root_t;
   logic [AW-1:0]                 rd_addr;
   logic [swsc_pkg::SQ_W-1:0]     w_sq;
   logic [swsc_pkg::DIFF_W-1:0]   nq_prod, ss_prod;
   logic [swsc_pkg::NUM_W-1:0]    sig_r;

   always_comb begin
      abs_diff = (req_payload.ask_price >= req_payload.bid_price)
               ? req_payload.ask_price - req_payload.bid_price
               : req_payload.bid_price - req_payload.ask_price;
      spread   = (abs_diff < swsc_pkg::SPREAD_FLOOR) ? swsc_pkg::SPREAD_FLOOR : abs_diff;
      div_sh   = {div_rem_ff, div_dvd_ff[swsc_pkg::DVD_W-1]};
      div_sub  = div_sh - {1'b0, div_dvs_ff};
      div_ge   = (div_sh >= {1'b0, div_dvs_ff});
      w_sat    = (div_quo_ff > swsc_pkg::DVD_W'(swsc_pkg::WEIGHT_MAX))
               ? swsc_pkg::WEIGHT_MAX : div_quo_ff[swsc_pkg::WEIGHT_W-1:0];
      root_t   = r_ff + bit_ff;
      rd_addr  = idx_ff[AW-1:0];
      w_sq     = swsc_pkg::SQ_W'(rd_data_ff) * swsc_pkg::SQ_W'(rd_data_ff);
      nq_prod  = swsc_pkg::DIFF_W'(count_ff) * swsc_pkg::DIFF_W'(q_ff);
      ss_prod  = swsc_pkg::DIFF_W'(sum_ff) * swsc_pkg::DIFF_W'(sum_ff);
      sig_r    = swsc_pkg::NUM_W'(sigma)
               * swsc_pkg::NUM_W'(r_ff[swsc_pkg::ROOT_W-1:0]);
   end

   // control counters and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         idx_ff     <= '0;
         dropped_ff <= 1'b0;
         last_ff    <= 1'b0;
         rdv_ff     <= 1'b0;
         div_cnt_ff <= '0;
         bit_ff     <= '0;
      end else begin
         rdv_ff <= cmd.sq_rd;
         if (cmd.capture) begin
            last_ff <= req_payload.last_quote;
            idx_ff  <= '0;
            if (count_ff == MAX_COUNT) dropped_ff <= 1'b1;
            else div_cnt_ff <= swsc_pkg::RECIP_STEPS;
         end
         if (cmd.store) count_ff <= count_ff + 1'b1;
         if (cmd.sq_rd || cmd.emit_next) idx_ff <= idx_ff + 1'b1;
         if (cmd.cap_num) idx_ff <= '0;
         if (cmd.div_step) div_cnt_ff <= div_cnt_ff - 1'b1;
         if (cmd.cap_div_start) div_cnt_ff <= swsc_pkg::CAP_STEPS;
         if (cmd.diff) bit_ff <= swsc_pkg::ROOT_BIT0;
         if (cmd.root_step) bit_ff <= bit_ff >> 2;
         if (cmd.set_clear) begin
            count_ff   <= '0;
            dropped_ff <= 1'b0;
         end
      end
   end

   // arithmetic
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         if (cmd.store) sum_ff <= sum_ff + swsc_pkg::SUM_W'(w_sat);
         if (cmd.set_clear) sum_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         q_ff       <= '0;
         div_rem_ff <= swsc_pkg::RECIP_REM0;
         div_dvd_ff <= '0;
         div_dvs_ff <= spread;
         div_quo_ff <= '0;
      end
      if (cmd.cap_div_start) begin
         div_rem_ff <= '0;
         div_dvd_ff <= num_ff[swsc_pkg::NUM_W-1:12];
         div_dvs_ff <= 32'(count_ff);
         div_quo_ff <= '0;
      end
      if (cmd.div_step) begin
         div_rem_ff <= div_ge ? div_sub[31:0] : div_sh[31:0];
         div_dvd_ff <= div_dvd_ff << 1;
         div_quo_ff <= {div_quo_ff[swsc_pkg::DVD_W-2:0], div_ge};
      end
      if (rdv_ff) q_ff <= q_ff + w_sq;
      if (cmd.nq) p1_ff <= nq_prod;
      if (cmd.ss) p2_ff <= ss_prod;
      if (cmd.diff) begin
         x_ff <= (p1_ff >= p2_ff) ? p1_ff - p2_ff : '0;
         r_ff <= '0;
      end
      if (cmd.root_step) begin
         if (x_ff >= root_t) begin
            x_ff <= x_ff - root_t;
            r_ff <= (r_ff >> 1) + bit_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
      end
      if (cmd.cap_num) begin
         num_ff <= swsc_pkg::NUM_W'({sum_ff, 12'd0}) + sig_r;
      end
   end

   // weight store
   always_ff @(posedge clock) begin
      if (cmd.store) store_mem[count_ff[AW-1:0]] <= w_sat;
      if (cmd.sq_rd || cmd.emit_rd) rd_data_ff <= store_mem[rd_addr];
   end

   always_comb begin
      rsp_payload.weight = (swsc_pkg::DVD_W'(rd_data_ff) > div_quo_ff)
                         ? div_quo_ff[swsc_pkg::WEIGHT_W-1:0] : rd_data_ff;
      rsp_payload.quote_index = 6'(idx_ff);
      rsp_payload.last_weight = (idx_ff == count_ff - 1'b1);
      rsp_payload.overflow    = dropped_ff;

      status.full       = (count_ff == MAX_COUNT);
      status.in_last    = req_payload.last_quote;
      status.last       = last_ff;
      status.div_done   = (div_cnt_ff == '0);
      status.sq_idx_end = (idx_ff == count_ff);
      status.sq_done    = (idx_ff == count_ff) && !rdv_ff;
      status.root_done  = (bit_ff == '0);
      status.emit_last  = (idx_ff == count_ff - 1'b1);
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_COUNT) else $error("quote count beyond capacity");
   a_root_bit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(bit_ff)) else $error("root bit not a single bit");
   a_div_cnt: assert property (@(posedge clock) disable iff (reset)
      div_cnt_ff <= swsc_pkg::CAP_STEPS) else $error("divider count out of range");
   a_rd_pipe: assert property (@(posedge clock) disable iff (reset)
      rdv_ff |-> idx_ff != '0) else $error("square pass read without index advance");

endmodule

[hdl/spread_weight_sigma_cap.sv]
// Capped reciprocal-spread weights. One quote per beat; each quote is accepted,
// run through a 23-step reciprocal divide and a done state, then stored.
// On the last quote: square pass, 29-step integer root, 34-step cap divide, then
// each result beat is read and held until taken. Unmarked quotes give no result.
// Synchronous active-high reset clears counts, sums, flags and sets sigma to 3.0.
// Depends on swsc_pkg, swsc_ctrl, swsc_dp.
module spread_weight_sigma_cap #(
   parameter int MAX_QUOTES = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  swsc_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output swsc_pkg::rsp_payload_type rsp_payload,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [2:0]                paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   logic [15:0]          sigma_ff;
   swsc_pkg::cmd_type    cmd;
   swsc_pkg::status_type status;

   assign pready = 1'b1;
   assign prdata = (paddr == swsc_pkg::ADDR_SIGMA) ? {16'd0, sigma_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) sigma_ff <= swsc_pkg::SIGMA_RESET;
      else if (psel && penable && pwrite && paddr == swsc_pkg::ADDR_SIGMA)
         sigma_ff <= pwdata[15:0];
   end

   swsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   swsc_dp #(.MAX_QUOTES(MAX_QUOTES)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .sigma       (sigma_ff),
      .rsp_payload (rsp_payload),
      .status      (status)
   );

endmodule

[bench/spread_weight_sigma_cap_tb.sv]
// Self-checking bench for spread_weight_sigma_cap: quote sets in, capped weights out.
// Depends on swsc_pkg and the spread_weight_sigma_cap RTL; needs no other files.
`timescale 1ns / 100ps

module spread_weight_sigma_cap_tb;

   localparam int MAX_Q = 64;
   localparam int CYCLE_LIMIT = 800000;
   localparam int LONG_HOLD = 2500;
   localparam int SETTLE = 60;

   // Weight predictor and store of expected weight beats
   class weight_board;
      logic [22:0]               weights[$];
      logic [28:0]               total;
      bit                        dropped;
      logic [15:0]               sigma_mult;
      swsc_pkg::rsp_payload_type pending_q[$];
      int                        errors;
      int                        checked;
      int                        sets_done;
      int                        overflow_sets;

      function void init();
         weights.delete();
         total = '0;
         dropped = 1'b0;
         sigma_mult = swsc_pkg::SIGMA_RESET;
         pending_q.delete();
         errors = 0;
         checked = 0;
         sets_done = 0;
         overflow_sets = 0;
      endfunction

      function void set_sigma(logic [15:0] m);
         sigma_mult = m;
      endfunction

      function logic [63:0] isqrt(logic [63:0] x);
         logic [63:0] r;
         logic [63:0] t;
         r = 0;
         for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= x) r = t;
         end
         return r;
      endfunction

      function void note_quote(swsc_pkg::req_payload_type q);
         logic [31:0]               sp;
         logic [63:0]               w, n, sq, d, r, cap;
         swsc_pkg::rsp_payload_type e;
         if (weights.size() < MAX_Q) begin
            sp = (q.ask_price >= q.bid_price) ? q.ask_price - q.bid_price
                                              : q.bid_price - q.ask_price;
            if (sp < swsc_pkg::SPREAD_FLOOR) sp = swsc_pkg::SPREAD_FLOOR;
            w = (64'd1 << 32) / sp;
            if (w > swsc_pkg::WEIGHT_MAX) w = swsc_pkg::WEIGHT_MAX;
            weights.push_back(w[22:0]);
            total = total + w[28:0];
         end else begin
            dropped = 1'b1;
         end
         if (!q.last_quote || weights.size() == 0) return;
         n = weights.size();
         sq = 0;
         foreach (weights[k]) sq += 64'(weights[k]) * 64'(weights[k]);
         d = n * sq;
         d = (d >= 64'(total) * 64'(total)) ? d - 64'(total) * 64'(total) : 0;
         r = isqrt(d);
         cap = (64'd4096 * total + 64'(sigma_mult) * r) / (64'd4096 * n);
         foreach (weights[k]) begin
            e.weight = (64'(weights[k]) > cap) ? cap[22:0] : weights[k];
            e.quote_index = k[5:0];
            e.last_weight = (k + 1 == weights.size());
            e.overflow = dropped;
            pending_q.push_back(e);
         end
         sets_done++;
         if (dropped) overflow_sets++;
         weights.delete();
         total = '0;
         dropped = 1'b0;
      endfunction

      function void check(swsc_pkg::rsp_payload_type a);
         swsc_pkg::rsp_payload_type e;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected weight beat %p", $time, a);
            errors++;
            return;
         end
         e = pending_q.pop_front();
         checked++;
         if (a.weight !== e.weight) begin
            $display("%0t: weight exp %0d got %0d", $time, e.weight, a.weight);
            errors++;
         end
         if (a.quote_index !== e.quote_index) begin
            $display("%0t: quote_index exp %0d got %0d", $time, e.quote_index,
                     a.quote_index);
            errors++;
         end
         if (a.last_weight !== e.last_weight) begin
            $display("%0t: last_weight exp %0b got %0b", $time, e.last_weight,
                     a.last_weight);
            errors++;
         end
         if (a.overflow !== e.overflow) begin
            $display("%0t: overflow exp %0b got %0b", $time, e.overflow, a.overflow);
            errors++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   swsc_pkg::req_payload_type req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   swsc_pkg::rsp_payload_type rsp_payload;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [2:0]                paddr = '0;
   logic [31:0]               pwdata = '0;
   logic [31:0]               prdata;
   logic                      pready;

   weight_board board = new();
   int          cycles = 0;
   int          hold_left = 0;
   bit          hold_armed = 1'b0;
   bit          hold_done = 1'b0;
   int          quotes_sent = 0;

   spread_weight_sigma_cap dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("spread_weight_sigma_cap_tb NOT OK");
         $finish;
      end
   end

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // receiver: random back-pressure plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) board.check(rsp_payload);
         if (hold_armed && !hold_done && rsp_valid) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (cycles % 1000 < 300) begin
            rsp_ready <= 1'b1;   // stretch with no stalls
         end else begin
            rsp_ready <= ($urandom_range(0, 99) < 70);
         end
      end
   end

   task automatic send_quote(logic [31:0] bid, logic [31:0] ask, logic last, bit idle);
      int gap;
      req_valid <= 1'b1;
      req_payload <= '{bid_price: bid, ask_price: ask, last_quote: last};
      do @(posedge clock); while (!req_ready);
      board.note_quote(req_payload);
      quotes_sent++;
      gap = idle ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_sigma(logic [15:0] m);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= swsc_pkg::ADDR_SIGMA;
      pwdata <= {16'd0, m};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[15:0] !== m) begin
         $display("%0t: sigma readback exp %0d got %0d", $time, m, prdata[15:0]);
         board.errors++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
      board.set_sigma(m);
   endtask

   function automatic logic [31:0] rand_ask(logic [31:0] bid);
      case ($urandom_range(0, 3))
         0: return bid + $urandom_range(0, 1500);
         1: return bid - $urandom_range(0, 1 << 18);
         2: return bid + $urandom_range(0, 1 << 22);
         default: return $urandom;
      endcase
   endfunction

   task automatic random_set(int n, bit idle);
      logic [31:0] bid;
      for (int i = 0; i < n; i++) begin
         bid = $urandom;
         send_quote(bid, rand_ask(bid), i == n - 1, idle);
      end
   endtask

   function automatic int pick_size();
      int p;
      p = $urandom_range(0, 99);
      if (p < 80) return $urandom_range(1, 6);
      if (p < 97) return $urandom_range(7, 16);
      return $urandom_range(17, 64);
   endfunction

   initial begin
      logic [15:0] sig_vals[$];
      board.init();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: spread floor, saturation, both price orders, extremes
      send_quote(32'd1000, 32'd1000, 1'b1, 1'b1);
      send_quote(32'd0, 32'hFFFF_FFFF, 1'b1, 1'b1);
      send_quote(32'hFFFF_FFFF, 32'd0, 1'b0, 1'b1);
      send_quote(32'd0, 32'd654, 1'b0, 1'b1);
      send_quote(32'd656, 32'd0, 1'b0, 1'b1);
      send_quote(32'd5, 32'd660, 1'b0, 1'b0);
      send_quote(32'h0001_0000, 32'h0002_0000, 1'b0, 1'b0);
      send_quote(32'h8000_0000, 32'h8000_0001, 1'b1, 1'b1);
      send_quote(32'h1234_5678, 32'h1234_5678, 1'b0, 1'b1);
      send_quote(32'h1234_5678, 32'h1244_5678, 1'b0, 1'b1);
      send_quote(32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b1);
      send_quote(32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b1);
      send_quote(32'h0000_0000, 32'h0000_0290, 1'b1, 1'b1);
      drain();

      sig_vals = '{16'd0, 16'hFFFF, 16'h1000, 16'($urandom_range(1, 65534)),
                   swsc_pkg::SIGMA_RESET};
      foreach (sig_vals[p]) begin
         write_sigma(sig_vals[p]);
         // full store: exactly MAX_Q, then beyond with drop
         if (p == 1) random_set(MAX_Q, 1'b0);
         if (p == 2) random_set(MAX_Q + 3, 1'b0);
         if (p == 3) begin
            hold_armed = 1'b1;   // receiver stalls long; sender keeps offering
            for (int s = 0; s < 8; s++) random_set(pick_size(), 1'b0);
            drain();             // sender pauses until everything is back
         end
         for (int s = 0; s < 4; s++) random_set(pick_size(), 1'b1);
         drain();
      end

      $display("%0d quotes in %0d sets (%0d with drops), %0d weight beats checked",
               quotes_sent, board.sets_done, board.overflow_sets, board.checked);
      $display("sigma multiplier swept through %0d settings incl. 0 and max",
               sig_vals.size());
      if (board.errors == 0 && board.pending_q.size() == 0) begin
         $display("spread_weight_sigma_cap_tb OK");
      end else begin
         $display("spread_weight_sigma_cap_tb NOT OK");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/swsc_pkg.sv
hdl/swsc_ctrl.sv
hdl/swsc_dp.sv
hdl/spread_weight_sigma_cap.sv
bench/spread_weight_sigma_cap_tb.sv
